@@ hdl/irdig_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irdig_pkg
// Types, constants and the digit glyph lookup for the integer to radix digits
// converter.
// ----------------------------------------------------------------------------
package irdig_pkg;

    localparam int VALUE_BITS = 31;
    localparam int RADIX_BITS = 6;
    localparam int CHAR_BITS  = 7;
    localparam int DIGITS_MAX = VALUE_BITS;
    localparam int COUNT_BITS = $clog2(DIGITS_MAX + 1);
    localparam int BIT_BITS   = $clog2(VALUE_BITS);

    localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);
    localparam logic [RADIX_BITS-1:0] DECIMAL_DIGITS = RADIX_BITS'(10);

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_A       = 7'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_ERROR   = 7'h00;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0] radix;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_BITS-1:0] digit_char;
        logic                 status;
        logic                 last;
    } t_out_item;

    // digit value to ascii: 0-9 then A-Z
    function automatic logic [CHAR_BITS-1:0] digit_glyph(input logic [RADIX_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d < DECIMAL_DIGITS) begin
            c = CHAR_ZERO + CHAR_BITS'(d);
        end else begin
            c = CHAR_A + CHAR_BITS'(d - DECIMAL_DIGITS);
        end
        return c;
    endfunction

endpackage

@@ hdl/integer_to_radix_digits_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top
// Converts a positive integer to its ASCII digits in a radix from 2 to 36,
// most significant digit first, with last on the final digit.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Each digit comes from a bit-serial
// restoring divider that produces one quotient bit per cycle; digits are
// pushed onto a shift-register stack and then popped out one per cycle while
// the output is not stalled. The input stays stalled while a transaction is
// being converted and emitted. A zero value or a radix outside 2 to 36 gives
// one error transaction (digit_char 0, status 1, last 1).
module integer_to_radix_digits_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  irdig_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output irdig_pkg::t_out_item o_out_item
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [1:0] S_ERR  = 2'd3;

    localparam int VB = irdig_pkg::VALUE_BITS;
    localparam int RB = irdig_pkg::RADIX_BITS;
    localparam int CB = irdig_pkg::COUNT_BITS;
    localparam int BB = irdig_pkg::BIT_BITS;

    logic [1:0]             r_state, n_state;
    logic [VB-1:0]          r_quo, n_quo;
    logic [RB-1:0]          r_rem, n_rem;
    logic [RB-1:0]          r_radix, n_radix;
    logic [BB-1:0]          r_bit_cnt, n_bit_cnt;
    logic [CB-1:0]          r_count, n_count;
    logic                   r_out_valid, n_out_valid;
    irdig_pkg::t_out_item   r_out, n_out;
    logic [RB-1:0]          r_stack [0:irdig_pkg::DIGITS_MAX-1];

    logic                   in_accept;
    logic                   in_ok;
    logic                   out_free;
    logic [RB:0]            div_trial;
    logic [RB:0]            div_diff;
    logic                   div_ge;
    logic [RB-1:0]          rem_step;
    logic [VB-1:0]          quo_step;
    logic                   push;
    logic                   pop;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_ok     = (i_in_item.value != '0)
                    && (i_in_item.radix >= irdig_pkg::RADIX_MIN)
                    && (i_in_item.radix <= irdig_pkg::RADIX_MAX);

    // one restoring division step
    assign div_trial = {r_rem, r_quo[VB-1]};
    assign div_diff  = div_trial - {1'b0, r_radix};
    assign div_ge    = (div_trial >= {1'b0, r_radix});
    assign rem_step  = div_ge ? div_diff[RB-1:0] : div_trial[RB-1:0];
    assign quo_step  = {r_quo[VB-2:0], div_ge};

    assign push = (r_state == S_DIV) && (r_bit_cnt == BB'(VB - 1));
    assign pop  = (r_state == S_EMIT) && out_free;

    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_radix     = r_radix;
        n_bit_cnt   = r_bit_cnt;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_quo     = i_in_item.value;
                    n_radix   = i_in_item.radix;
                    n_rem     = '0;
                    n_bit_cnt = '0;
                    n_count   = '0;
                    n_state   = in_ok ? S_DIV : S_ERR;
                end
            end
            S_DIV: begin
                n_quo = quo_step;
                if (push) begin
                    n_count   = r_count + CB'(1);
                    n_rem     = '0;
                    n_bit_cnt = '0;
                    if ((quo_step == '0) || (r_count == CB'(irdig_pkg::DIGITS_MAX - 1))) begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_rem     = rem_step;
                    n_bit_cnt = r_bit_cnt + BB'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.digit_char  = irdig_pkg::digit_glyph(r_stack[0]);
                    n_out.status      = irdig_pkg::STATUS_OK;
                    n_out.last        = (r_count == CB'(1));
                    n_count           = r_count - CB'(1);
                    if (r_count == CB'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.digit_char = irdig_pkg::CHAR_ERROR;
                    n_out.status     = irdig_pkg::STATUS_ERROR;
                    n_out.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_bit_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_bit_cnt   <= n_bit_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_out   <= n_out;
    end

    // digit stack: push at the head, newest digit is the most significant
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[0] <= rem_step;
            for (int i = 1; i < irdig_pkg::DIGITS_MAX; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (pop) begin
            r_stack[irdig_pkg::DIGITS_MAX-1] <= r_stack[irdig_pkg::DIGITS_MAX-1];
            for (int i = 0; i < irdig_pkg::DIGITS_MAX - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // error transaction is always a single final one with a zero character
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status |-> o_out_item.last
            && (o_out_item.digit_char == irdig_pkg::CHAR_ERROR))
        else $error("error transaction not final or not zero");

    // an accepted transaction blocks the input until it is done
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input taken while busy");

    // the stack never overflows while dividing
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count < CB'(irdig_pkg::DIGITS_MAX)))
        else $error("digit count overflow");

    // emitting never starts from an empty stack
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_count != '0))
        else $error("emit with no digits");

endmodule

@@ tb/sv/integer_to_radix_digits_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_checker
// Watches both channels of the radix digit converter. Each accepted input
// transaction is expanded into the digit characters it should produce, most
// significant first. Each accepted output transaction is compared field by
// field with the oldest pending digit.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  irdig_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  irdig_pkg::t_out_item i_out_item,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam logic [8*36-1:0] GLYPHS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    irdig_pkg::t_out_item digits_due[$];

    task automatic expand_digits(input irdig_pkg::t_in_item item);
        logic [irdig_pkg::VALUE_BITS-1:0] quotient;
        logic [irdig_pkg::RADIX_BITS-1:0] remainders [irdig_pkg::DIGITS_MAX];
        int                               ndig;
        irdig_pkg::t_out_item             r;
        if (item.value == '0 || item.radix < irdig_pkg::RADIX_MIN
                || item.radix > irdig_pkg::RADIX_MAX) begin
            r.digit_char = irdig_pkg::CHAR_ERROR;
            r.status     = irdig_pkg::STATUS_ERROR;
            r.last       = 1'b1;
            digits_due.push_back(r);
        end else begin
            quotient = item.value;
            ndig     = 0;
            while (quotient != '0 && ndig < irdig_pkg::DIGITS_MAX) begin
                remainders[ndig] = irdig_pkg::RADIX_BITS'(quotient % item.radix);
                quotient         = quotient / item.radix;
                ndig++;
            end
            for (int k = ndig - 1; k >= 0; k--) begin
                r.digit_char = GLYPHS[8*(35 - int'(remainders[k])) +: irdig_pkg::CHAR_BITS];
                r.status     = irdig_pkg::STATUS_OK;
                r.last       = (k == 0);
                digits_due.push_back(r);
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        irdig_pkg::t_out_item want;
        logic                 bad;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (digits_due.size() == 0) begin
                    $display("%0t unexpected transaction: expected none actual %h",
                             $time, i_out_item);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = digits_due.pop_front();
                    bad  = 1'b0;
                    if (i_out_item.digit_char !== want.digit_char) begin
                        $display("%0t digit_char: expected %h actual %h",
                                 $time, want.digit_char, i_out_item.digit_char);
                        bad = 1'b1;
                    end
                    if (i_out_item.status !== want.status) begin
                        $display("%0t status: expected %b actual %b",
                                 $time, want.status, i_out_item.status);
                        bad = 1'b1;
                    end
                    if (i_out_item.last !== want.last) begin
                        $display("%0t last: expected %b actual %b",
                                 $time, want.last, i_out_item.last);
                        bad = 1'b1;
                    end
                    if (bad) begin
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expand_digits(i_in_item);
            end
            o_pending = digits_due.size();
        end
    end

endmodule

@@ tb/sv/integer_to_radix_digits_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top_tb
// Drives the radix digit converter with directed corner values and random
// conversions, stalls and idles both channels at random, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_top_tb;

    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 1100;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 in_stall;
    irdig_pkg::t_in_item  in_item;
    logic                 out_valid;
    logic                 out_stall;
    irdig_pkg::t_out_item out_item;
    int                   fail_count;
    int                   pending;
    logic                 calm;

    integer_to_radix_digits_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    integer_to_radix_digits_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        int r;
        int g;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            g = 0;
        end else if (r < 85) begin
            g = $urandom_range(1, 3);
        end else if (r < 97) begin
            g = $urandom_range(4, 12);
        end else begin
            g = $urandom_range(20, 80);
        end
        return g;
    endfunction

    // mostly well-formed conversions of varied length, some invalid ones
    function automatic irdig_pkg::t_in_item random_item();
        irdig_pkg::t_in_item it;
        int                  pick;
        pick     = $urandom_range(0, 99);
        it.value = irdig_pkg::VALUE_BITS'($urandom >> $urandom_range(1, 31));
        it.radix = irdig_pkg::RADIX_BITS'($urandom_range(irdig_pkg::RADIX_MIN,
                                                          irdig_pkg::RADIX_MAX));
        if (it.value == '0) begin
            it.value = irdig_pkg::VALUE_BITS'(1);
        end
        if (pick < 6) begin
            it.value = '0;
        end else if (pick < 10) begin
            it.radix = irdig_pkg::RADIX_BITS'($urandom_range(0, 1));
        end else if (pick < 15) begin
            it.radix = irdig_pkg::RADIX_BITS'($urandom_range(37, 63));
        end
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [irdig_pkg::VALUE_BITS-1:0] value,
                             input logic [irdig_pkg::RADIX_BITS-1:0] radix);
        int                  gap;
        irdig_pkg::t_in_item item;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item.value = value;
        item.radix = radix;
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        out_stall = 1'b0;
        forever begin
            int run;
            int g;
            run = $urandom_range(1, 8);
            out_stall <= 1'b0;
            repeat (run) @(negedge i_clk);
            g = calm ? 0 : pick_gap();
            if (g > 0) begin
                out_stall <= 1'b1;
                repeat (g) @(negedge i_clk);
            end
        end
    end

    initial begin
        irdig_pkg::t_in_item it;
        in_valid = 1'b0;
        in_item  = '0;
        i_rst_n  = 1'b0;
        calm     = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corner values, single digits, invalid values and radices
        send_item(31'h7FFF_FFFF, 6'd2);
        send_item(31'h7FFF_FFFF, 6'd36);
        send_item(31'h7FFF_FFFF, 6'd16);
        send_item(31'h7FFF_FFFF, 6'd10);
        send_item(31'd1, 6'd2);
        send_item(31'd1, 6'd36);
        send_item(31'd35, 6'd36);
        send_item(31'd36, 6'd36);
        send_item(31'd10, 6'd10);
        send_item(31'd9, 6'd10);
        send_item(31'h4000_0000, 6'd2);
        send_item(31'h2AAA_AAAA, 6'd2);
        send_item(31'h5555_5555, 6'd3);
        send_item(31'd0, 6'd10);
        send_item(31'd0, 6'd0);
        send_item(31'd5, 6'd0);
        send_item(31'd5, 6'd1);
        send_item(31'd5, 6'd37);
        send_item(31'd5, 6'd63);
        send_item(31'h7FFF_FFFF, 6'd35);
        wait_drained();
        @(negedge i_clk);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 100 && i < 140);
            if (i == 180) begin
                wait_drained();
                @(negedge i_clk);
            end
            it = random_item();
            send_item(it.value, it.radix);
        end
        calm = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/irdig_pkg.sv
hdl/integer_to_radix_digits_top.sv
tb/sv/integer_to_radix_digits_checker.sv
tb/sv/integer_to_radix_digits_top_tb.sv
